// ===== rtl/alfp_pkg.sv =====
// Package for the array linked list with free pool: sizes, item and control
// types, status and operation codes, and the microcode ROM of the sequencer.
// Depends on nothing; every other file uses it by scoped names.
package alfp_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int LINK_W  = $clog2(ENTRIES + 1);
	localparam int UPC_W   = 5;

	// link value meaning "none"
	localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

	localparam logic [1:0] OP_APPEND       = 2'd0;
	localparam logic [1:0] OP_REMOVE       = 2'd1;
	localparam logic [1:0] OP_INSERT_AFTER = 2'd2;
	localparam logic [1:0] OP_REMOVE_AFTER = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         position;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
	} out_item_t;

	// datapath micro-operations
	typedef enum logic [4:0] {
		A_NOP,
		A_LATCH,
		A_LOC_INIT,
		A_READ_CUR,
		A_LOC_STEP,
		A_LATCH_NEXT,
		A_READ_NXT,
		A_UNLINK,
		A_GIVE_NXT,
		A_WR_PRED,
		A_SET_HEAD_NXT,
		A_GIVE_POS,
		A_READ_FREE,
		A_TAKE_MID,
		A_WR_POS_CELL,
		A_TAKE_TAIL,
		A_TAIL_STEP,
		A_WR_TAIL,
		A_SET_HEAD_CELL,
		A_SET_BADPOS,
		A_SET_ABSENT,
		A_SET_NOFREE,
		A_EMIT
	} act_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_IS_APPEND,
		C_POS_BAD,
		C_LOC_MORE,
		C_NOT_FOUND,
		C_OP_REMOVE,
		C_OP_INSERT,
		C_NXT_NIL,
		C_PRED_NIL,
		C_FREE_EMPTY,
		C_LIST_EMPTY,
		C_TAIL_MORE
	} cond_t;

	typedef struct packed {
		act_t             act;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic is_append;
		logic pos_bad;
		logic loc_more;
		logic not_found;
		logic op_remove;
		logic op_insert;
		logic nxt_nil;
		logic pred_nil;
		logic free_empty;
		logic list_empty;
		logic tail_more;
	} flags_t;

	// microprogram addresses
	localparam logic [UPC_W-1:0] U_IDLE      = 5'd0;
	localparam logic [UPC_W-1:0] U_DECODE    = 5'd1;
	localparam logic [UPC_W-1:0] U_RANGE     = 5'd2;
	localparam logic [UPC_W-1:0] U_LOC_RD    = 5'd3;
	localparam logic [UPC_W-1:0] U_LOC_WALK  = 5'd4;
	localparam logic [UPC_W-1:0] U_LOC_END   = 5'd5;
	localparam logic [UPC_W-1:0] U_DISP_RM   = 5'd6;
	localparam logic [UPC_W-1:0] U_DISP_INS  = 5'd7;
	localparam logic [UPC_W-1:0] U_RA_RD     = 5'd8;
	localparam logic [UPC_W-1:0] U_RA_UNLINK = 5'd9;
	localparam logic [UPC_W-1:0] U_RA_FREE   = 5'd10;
	localparam logic [UPC_W-1:0] U_RM_CHK    = 5'd11;
	localparam logic [UPC_W-1:0] U_RM_PRED   = 5'd12;
	localparam logic [UPC_W-1:0] U_RM_HEAD   = 5'd13;
	localparam logic [UPC_W-1:0] U_RM_FREE   = 5'd14;
	localparam logic [UPC_W-1:0] U_IA_RD     = 5'd15;
	localparam logic [UPC_W-1:0] U_IA_TAKE   = 5'd16;
	localparam logic [UPC_W-1:0] U_IA_LINK   = 5'd17;
	localparam logic [UPC_W-1:0] U_AP_RD     = 5'd18;
	localparam logic [UPC_W-1:0] U_AP_TAKE   = 5'd19;
	localparam logic [UPC_W-1:0] U_AP_TRD    = 5'd20;
	localparam logic [UPC_W-1:0] U_AP_WALK   = 5'd21;
	localparam logic [UPC_W-1:0] U_AP_LINK   = 5'd22;
	localparam logic [UPC_W-1:0] U_AP_HEAD   = 5'd23;
	localparam logic [UPC_W-1:0] U_F_BADPOS  = 5'd24;
	localparam logic [UPC_W-1:0] U_F_ABSENT  = 5'd25;
	localparam logic [UPC_W-1:0] U_F_NOFREE  = 5'd26;
	localparam logic [UPC_W-1:0] U_FIN       = 5'd27;

	function automatic ctrl_t cw(input act_t a, input cond_t c, input logic [UPC_W-1:0] t);
		ctrl_t w;
		w.act    = a;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	// control ROM: taken jump goes to target, otherwise to the next word
	function automatic ctrl_t ucode(input logic [UPC_W-1:0] upc);
		ctrl_t w;
		unique case (upc)
			U_IDLE:      w = cw(A_LATCH,         C_NO_START,   U_IDLE);
			U_DECODE:    w = cw(A_LOC_INIT,      C_IS_APPEND,  U_AP_RD);
			U_RANGE:     w = cw(A_NOP,           C_POS_BAD,    U_F_BADPOS);
			U_LOC_RD:    w = cw(A_READ_CUR,      C_NEVER,      U_IDLE);
			U_LOC_WALK:  w = cw(A_LOC_STEP,      C_LOC_MORE,   U_LOC_WALK);
			U_LOC_END:   w = cw(A_LATCH_NEXT,    C_NOT_FOUND,  U_F_ABSENT);
			U_DISP_RM:   w = cw(A_NOP,           C_OP_REMOVE,  U_RM_CHK);
			U_DISP_INS:  w = cw(A_NOP,           C_OP_INSERT,  U_IA_RD);
			U_RA_RD:     w = cw(A_READ_NXT,      C_NXT_NIL,    U_F_BADPOS);
			U_RA_UNLINK: w = cw(A_UNLINK,        C_NEVER,      U_IDLE);
			U_RA_FREE:   w = cw(A_GIVE_NXT,      C_ALWAYS,     U_FIN);
			U_RM_CHK:    w = cw(A_NOP,           C_PRED_NIL,   U_RM_HEAD);
			U_RM_PRED:   w = cw(A_WR_PRED,       C_ALWAYS,     U_RM_FREE);
			U_RM_HEAD:   w = cw(A_SET_HEAD_NXT,  C_NEVER,      U_IDLE);
			U_RM_FREE:   w = cw(A_GIVE_POS,      C_ALWAYS,     U_FIN);
			U_IA_RD:     w = cw(A_READ_FREE,     C_FREE_EMPTY, U_F_NOFREE);
			U_IA_TAKE:   w = cw(A_TAKE_MID,      C_NEVER,      U_IDLE);
			U_IA_LINK:   w = cw(A_WR_POS_CELL,   C_ALWAYS,     U_FIN);
			U_AP_RD:     w = cw(A_READ_FREE,     C_FREE_EMPTY, U_F_NOFREE);
			U_AP_TAKE:   w = cw(A_TAKE_TAIL,     C_LIST_EMPTY, U_AP_HEAD);
			U_AP_TRD:    w = cw(A_READ_CUR,      C_NEVER,      U_IDLE);
			U_AP_WALK:   w = cw(A_TAIL_STEP,     C_TAIL_MORE,  U_AP_WALK);
			U_AP_LINK:   w = cw(A_WR_TAIL,       C_ALWAYS,     U_FIN);
			U_AP_HEAD:   w = cw(A_SET_HEAD_CELL, C_ALWAYS,     U_FIN);
			U_F_BADPOS:  w = cw(A_SET_BADPOS,    C_ALWAYS,     U_FIN);
			U_F_ABSENT:  w = cw(A_SET_ABSENT,    C_ALWAYS,     U_FIN);
			U_F_NOFREE:  w = cw(A_SET_NOFREE,    C_NEVER,      U_IDLE);
			U_FIN:       w = cw(A_EMIT,          C_ALWAYS,     U_IDLE);
			default:     w = cw(A_EMIT,          C_ALWAYS,     U_IDLE);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/alfp_useq.sv =====
// Microcode sequencer: step counter, control ROM and jump condition select.
// Depends on alfp_pkg.
module alfp_useq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  alfp_pkg::flags_t     flags,
	output alfp_pkg::ctrl_t      ctrl,
	output logic                 busy
);

	logic [alfp_pkg::UPC_W-1:0] upc_q;
	logic                       taken;

	assign ctrl = alfp_pkg::ucode(upc_q);
	assign busy = (upc_q != alfp_pkg::U_IDLE);

	always_comb begin
		unique case (ctrl.cond)
			alfp_pkg::C_NEVER:      taken = 1'b0;
			alfp_pkg::C_ALWAYS:     taken = 1'b1;
			alfp_pkg::C_NO_START:   taken = !start;
			alfp_pkg::C_IS_APPEND:  taken = flags.is_append;
			alfp_pkg::C_POS_BAD:    taken = flags.pos_bad;
			alfp_pkg::C_LOC_MORE:   taken = flags.loc_more;
			alfp_pkg::C_NOT_FOUND:  taken = flags.not_found;
			alfp_pkg::C_OP_REMOVE:  taken = flags.op_remove;
			alfp_pkg::C_OP_INSERT:  taken = flags.op_insert;
			alfp_pkg::C_NXT_NIL:    taken = flags.nxt_nil;
			alfp_pkg::C_PRED_NIL:   taken = flags.pred_nil;
			alfp_pkg::C_FREE_EMPTY: taken = flags.free_empty;
			alfp_pkg::C_LIST_EMPTY: taken = flags.list_empty;
			alfp_pkg::C_TAIL_MORE:  taken = flags.tail_more;
			default:                taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= alfp_pkg::U_IDLE;
		end else if (taken) begin
			upc_q <= ctrl.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not start the program");

	a_walk_stays: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == alfp_pkg::U_LOC_WALK && flags.loc_more |=> upc_q == alfp_pkg::U_LOC_WALK)
		else $error("locate walk left early");

	a_fin_returns: assert property (@(posedge clk) disable iff (!arst_n)
		upc_q == alfp_pkg::U_FIN |=> !busy)
		else $error("program did not return to idle after finish");

endmodule

// ===== rtl/alfp_dpath.sv =====
// Datapath: link and value stores, list and free heads, walk registers,
// result register. Driven one control word per cycle by alfp_useq.
// Depends on alfp_pkg.
module alfp_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  alfp_pkg::in_item_t   cmd,
	input  alfp_pkg::ctrl_t      ctrl,
	output alfp_pkg::flags_t     flags,
	output alfp_pkg::out_item_t  result,
	output logic                 done
);

	localparam int IW = alfp_pkg::IDX_W;
	localparam int LW = alfp_pkg::LINK_W;

	logic [LW-1:0]          link_mem [alfp_pkg::ENTRIES];
	logic [31:0]            val_mem  [alfp_pkg::ENTRIES];
	logic [alfp_pkg::ENTRIES-1:0] vld_q;

	alfp_pkg::in_item_t     cmd_q;
	alfp_pkg::out_item_t    res_q;
	logic                   done_q;
	logic [LW-1:0]          free_head_q;
	logic [LW-1:0]          list_head_q;
	logic [LW-1:0]          cur_q;
	logic [LW-1:0]          prev_q;
	logic [LW-1:0]          nxt_q;
	logic [LW-1:0]          cell_q;
	logic [LW-1:0]          k_q;
	logic [LW-1:0]          rd_q;

	logic [LW-1:0]          pos_l;
	logic [LW-1:0]          raddr;
	logic [LW-1:0]          waddr;
	logic [LW-1:0]          wdata;
	logic                   link_we;
	logic                   val_we;
	logic [31:0]            vdata;
	logic [IW-1:0]          ridx;
	logic [IW-1:0]          widx;
	logic                   cur_live;

	assign pos_l    = LW'(cmd_q.position);
	assign ridx     = raddr[IW-1:0];
	assign widx     = waddr[IW-1:0];
	// walk cursor still inside the list and under the link bound
	assign cur_live = (cur_q < alfp_pkg::NIL) && (k_q != alfp_pkg::NIL);

	assign flags.is_append  = (cmd_q.operation == alfp_pkg::OP_APPEND);
	assign flags.pos_bad    = (pos_l >= alfp_pkg::NIL);
	assign flags.loc_more   = cur_live && (cur_q != pos_l);
	assign flags.not_found  = !(cur_live && (cur_q == pos_l));
	assign flags.op_remove  = (cmd_q.operation == alfp_pkg::OP_REMOVE);
	assign flags.op_insert  = (cmd_q.operation == alfp_pkg::OP_INSERT_AFTER);
	assign flags.nxt_nil    = (nxt_q >= alfp_pkg::NIL);
	assign flags.pred_nil   = (prev_q >= alfp_pkg::NIL);
	assign flags.free_empty = (free_head_q >= alfp_pkg::NIL);
	assign flags.list_empty = (list_head_q >= alfp_pkg::NIL);
	assign flags.tail_more  = (rd_q < alfp_pkg::NIL) && (k_q != alfp_pkg::NIL);

	assign result = res_q;
	assign done   = done_q;

	// memory port decode
	always_comb begin
		raddr   = cur_q;
		waddr   = pos_l;
		wdata   = free_head_q;
		link_we = 1'b0;
		val_we  = 1'b0;
		vdata   = 32'd0;
		unique case (ctrl.act)
			alfp_pkg::A_LOC_STEP:  raddr = flags.loc_more ? rd_q : cur_q;
			alfp_pkg::A_TAIL_STEP: raddr = flags.tail_more ? rd_q : cur_q;
			alfp_pkg::A_READ_FREE: raddr = free_head_q;
			alfp_pkg::A_READ_NXT:  raddr = nxt_q;
			alfp_pkg::A_UNLINK: begin
				link_we = 1'b1;
				wdata   = rd_q;
			end
			alfp_pkg::A_GIVE_NXT: begin
				link_we = 1'b1;
				val_we  = 1'b1;
				waddr   = nxt_q;
			end
			alfp_pkg::A_WR_PRED: begin
				link_we = 1'b1;
				waddr   = prev_q;
				wdata   = nxt_q;
			end
			alfp_pkg::A_GIVE_POS: begin
				link_we = 1'b1;
				val_we  = 1'b1;
			end
			alfp_pkg::A_TAKE_MID: begin
				link_we = 1'b1;
				val_we  = 1'b1;
				waddr   = free_head_q;
				wdata   = nxt_q;
				vdata   = cmd_q.value;
			end
			alfp_pkg::A_WR_POS_CELL: begin
				link_we = 1'b1;
				wdata   = cell_q;
			end
			alfp_pkg::A_TAKE_TAIL: begin
				link_we = 1'b1;
				val_we  = 1'b1;
				waddr   = free_head_q;
				wdata   = alfp_pkg::NIL;
				vdata   = cmd_q.value;
			end
			alfp_pkg::A_WR_TAIL: begin
				link_we = 1'b1;
				waddr   = cur_q;
				wdata   = cell_q;
			end
			default: ;
		endcase
	end

	// stores: an entry never written reads as its reset link, i+1
	always_ff @(posedge clk) begin
		if (link_we && waddr < alfp_pkg::NIL) begin
			link_mem[widx] <= wdata;
		end
		if (val_we && waddr < alfp_pkg::NIL) begin
			val_mem[widx] <= vdata;
		end
		if (raddr >= alfp_pkg::NIL) begin
			rd_q <= alfp_pkg::NIL;
		end else if (vld_q[ridx]) begin
			rd_q <= link_mem[ridx];
		end else begin
			rd_q <= LW'(ridx) + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (link_we && waddr < alfp_pkg::NIL) begin
			vld_q[widx] <= 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			list_head_q <= alfp_pkg::NIL;
			k_q         <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (ctrl.act == alfp_pkg::A_EMIT);
			unique case (ctrl.act)
				alfp_pkg::A_LOC_INIT:      k_q <= '0;
				alfp_pkg::A_LOC_STEP:      if (flags.loc_more) k_q <= k_q + 1'b1;
				alfp_pkg::A_TAIL_STEP:     if (flags.tail_more) k_q <= k_q + 1'b1;
				alfp_pkg::A_GIVE_NXT:      free_head_q <= nxt_q;
				alfp_pkg::A_GIVE_POS:      free_head_q <= pos_l;
				alfp_pkg::A_SET_HEAD_NXT:  list_head_q <= nxt_q;
				alfp_pkg::A_SET_HEAD_CELL: list_head_q <= cell_q;
				alfp_pkg::A_TAKE_MID:      free_head_q <= rd_q;
				alfp_pkg::A_TAKE_TAIL: begin
					free_head_q <= rd_q;
					k_q         <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload and walk registers
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			alfp_pkg::A_LATCH:         if (start) cmd_q <= cmd;
			alfp_pkg::A_LOC_INIT: begin
				cur_q  <= list_head_q;
				prev_q <= alfp_pkg::NIL;
			end
			alfp_pkg::A_LOC_STEP: begin
				if (flags.loc_more) begin
					prev_q <= cur_q;
					cur_q  <= rd_q;
				end
			end
			alfp_pkg::A_LATCH_NEXT:    nxt_q <= rd_q;
			alfp_pkg::A_GIVE_NXT:      res_q <= '{status: alfp_pkg::ST_DONE, slot: 4'(nxt_q)};
			alfp_pkg::A_GIVE_POS:      res_q <= '{status: alfp_pkg::ST_DONE, slot: 4'(pos_l)};
			alfp_pkg::A_TAKE_MID:      cell_q <= free_head_q;
			alfp_pkg::A_WR_POS_CELL:   res_q <= '{status: alfp_pkg::ST_DONE, slot: 4'(cell_q)};
			alfp_pkg::A_TAKE_TAIL: begin
				cell_q <= free_head_q;
				cur_q  <= list_head_q;
			end
			alfp_pkg::A_TAIL_STEP:     if (flags.tail_more) cur_q <= rd_q;
			alfp_pkg::A_WR_TAIL:       res_q <= '{status: alfp_pkg::ST_DONE, slot: 4'(cell_q)};
			alfp_pkg::A_SET_HEAD_CELL: res_q <= '{status: alfp_pkg::ST_DONE, slot: 4'(cell_q)};
			alfp_pkg::A_SET_BADPOS:    res_q <= '{status: alfp_pkg::ST_BADPOS, slot: 4'd0};
			alfp_pkg::A_SET_ABSENT:    res_q <= '{status: alfp_pkg::ST_ABSENT, slot: 4'd0};
			alfp_pkg::A_SET_NOFREE:    res_q <= '{status: alfp_pkg::ST_NOFREE, slot: 4'd0};
			default: ;
		endcase
	end

	a_slot_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (res_q.status == alfp_pkg::ST_DONE) || (res_q.slot == 4'd0))
		else $error("error result carries a nonzero slot");

	a_heads_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q < alfp_pkg::NIL) |-> (free_head_q != list_head_q))
		else $error("free list and live list share their head entry");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= alfp_pkg::NIL)
		else $error("walk count ran past the entry count");

endmodule

// ===== rtl/array_linked_list_free_pool.sv =====
// Top level of the array linked list with free pool; uses alfp_pkg, alfp_useq, alfp_dpath.
// The locate and tail walks follow one link per cycle, at most ENTRIES links per walk.
// Throughput: one item at a time; the next start is taken in the cycle done strobes.
// The result shows for one cycle with done; the receiver cannot stall.
// Reset: list empty, all entries on the free list, no clearing pass needed.
module array_linked_list_free_pool (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  alfp_pkg::in_item_t   cmd,
	output logic                 done,
	output alfp_pkg::out_item_t  result
);

	alfp_pkg::ctrl_t  ctrl;
	alfp_pkg::flags_t flags;

	alfp_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	alfp_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.ctrl   (ctrl),
		.flags  (flags),
		.result (result),
		.done   (done)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while an item is in work");

	a_no_done_early: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobed right after accepting an item");

endmodule
